>>> hdl/stfp_pkg.sv
`default_nettype none

package stfp_pkg;

   localparam int MAX_TEXT = 256;
   localparam int LEN_W = $clog2(MAX_TEXT + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int ACC_W = 17;
   localparam logic [ACC_W-1:0] ACC_SAT = 17'h1FFFF;

   localparam logic [15:0] ID_LOWEST_RESET = 16'd31000;
   localparam logic [15:0] ID_HIGHEST_RESET = 16'hFFFF;

   localparam logic [15:0] UNIT_NUL = 16'h0000;
   localparam logic [15:0] UNIT_TAB = 16'h0009;
   localparam logic [15:0] UNIT_LF = 16'h000A;
   localparam logic [15:0] UNIT_CR = 16'h000D;
   localparam logic [15:0] UNIT_SPACE = 16'h0020;
   localparam logic [15:0] UNIT_QUOTE = 16'h0022;
   localparam logic [15:0] UNIT_ZERO = 16'h0030;
   localparam logic [15:0] UNIT_NINE = 16'h0039;
   localparam logic [15:0] UNIT_SEMI = 16'h003B;
   localparam logic [15:0] UNIT_EQ = 16'h003D;
   localparam logic [15:0] UNIT_BACKSLASH = 16'h005C;
   localparam logic [15:0] UNIT_R = 16'h0072;
   localparam logic [15:0] UNIT_N = 16'h006E;
   localparam logic [15:0] UNIT_T = 16'h0074;

   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ID_LOWEST  = 1'b0,
      CSR_ID_HIGHEST = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_TEXT = 2'd0,
      KIND_END  = 2'd1,
      KIND_OK   = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [15:0] entry_id;
      logic [15:0] text_unit;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type [2:0] item;
   } bundle_type;

   typedef struct packed {
      logic [15:0] id_lowest;
      logic [15:0] id_highest;
   } cfg_type;

   function automatic bundle_type push_result(bundle_type b, kind_type k,
                                              logic [15:0] id, logic [15:0] u);
      bundle_type r;
      r = b;
      if (b.count != 2'd3) begin
         r.item[b.count].kind = k;
         r.item[b.count].entry_id = id;
         r.item[b.count].text_unit = u;
         r.count = b.count + 2'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/stfp_req_if.sv
`default_nettype none

interface stfp_req_if;
   logic valid;
   logic ready;
   logic [15:0] code_unit;
   logic final_unit;

   modport source(output valid, output code_unit, output final_unit, input ready);
   modport sink(input valid, input code_unit, input final_unit, output ready);
endinterface

`default_nettype wire

>>> hdl/stfp_rsp_if.sv
`default_nettype none

interface stfp_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [15:0] entry_id;
   logic [15:0] text_unit;

   modport source(output valid, output kind, output entry_id, output text_unit, input ready);
   modport sink(input valid, input kind, input entry_id, input text_unit, output ready);
endinterface

`default_nettype wire

>>> hdl/stfp_front.sv
`default_nettype none

module stfp_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire stfp_pkg::cfg_type cfg,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [15:0] req_code_unit,
   input  wire logic req_final_unit,
   input  wire logic queue_full,
   output logic push_valid,
   output stfp_pkg::bundle_type push_data
);

   typedef enum logic [10:0] {
      PH_BETWEEN       = 11'b000_0000_0001,
      PH_TOP_COMMENT   = 11'b000_0000_0010,
      PH_ID            = 11'b000_0000_0100,
      PH_SKIP_LINE     = 11'b000_0000_1000,
      PH_WANT_EQ       = 11'b000_0001_0000,
      PH_EQ_COMMENT    = 11'b000_0010_0000,
      PH_WANT_QUOTE    = 11'b000_0100_0000,
      PH_QUOTE_COMMENT = 11'b000_1000_0000,
      PH_TEXT          = 11'b001_0000_0000,
      PH_ESCAPE        = 11'b010_0000_0000,
      PH_FAILED        = 11'b100_0000_0000
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [stfp_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [stfp_pkg::LEN_W-1:0] len_ff, len_in;

   logic [15:0] c;
   logic is_delim, is_digit, run_id, in_range, esc_known, accept;
   logic [stfp_pkg::ACC_W-1:0] acc_base;
   logic [stfp_pkg::ACC_W+3:0] acc_wide;
   logic [stfp_pkg::LEN_W-1:0] len1, len2;
   logic [15:0] entry, esc_unit;
   stfp_pkg::bundle_type b;

   assign c = req_code_unit;
   assign accept = req_valid && req_ready;
   assign req_ready = !queue_full;
   assign entry = acc_ff[15:0];
   assign len1 = len_ff + stfp_pkg::LEN_W'(1);
   assign len2 = len_ff + stfp_pkg::LEN_W'(2);

   assign is_delim = (c == stfp_pkg::UNIT_SPACE) || (c == stfp_pkg::UNIT_LF) ||
                     (c == stfp_pkg::UNIT_CR) || (c == stfp_pkg::UNIT_NUL) ||
                     (c == stfp_pkg::UNIT_TAB);
   assign is_digit = (c >= stfp_pkg::UNIT_ZERO) && (c <= stfp_pkg::UNIT_NINE);

   always_comb begin
      esc_known = 1'b1;
      esc_unit = c;
      unique case (c) inside
         stfp_pkg::UNIT_R: esc_unit = stfp_pkg::UNIT_CR;
         stfp_pkg::UNIT_N: esc_unit = stfp_pkg::UNIT_LF;
         stfp_pkg::UNIT_T: esc_unit = stfp_pkg::UNIT_TAB;
         stfp_pkg::UNIT_BACKSLASH, stfp_pkg::UNIT_QUOTE: esc_unit = c;
         default: esc_known = 1'b0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in = acc_ff;
      len_in = len_ff;
      b = '0;
      run_id = 1'b0;
      acc_base = acc_ff;
      unique case (phase_ff) inside
         PH_BETWEEN: begin
            if (is_delim) begin
               phase_in = phase_ff;
            end else if (c == stfp_pkg::UNIT_SEMI) begin
               phase_in = PH_TOP_COMMENT;
            end else begin
               run_id = 1'b1;
               acc_base = '0;
               len_in = '0;
            end
         end
         PH_TOP_COMMENT, PH_SKIP_LINE: begin
            if (c == stfp_pkg::UNIT_LF) phase_in = PH_BETWEEN;
         end
         PH_ID: run_id = 1'b1;
         PH_WANT_EQ: begin
            if (is_delim) begin
               phase_in = phase_ff;
            end else if (c == stfp_pkg::UNIT_SEMI) begin
               phase_in = PH_EQ_COMMENT;
            end else if (c == stfp_pkg::UNIT_EQ) begin
               phase_in = PH_WANT_QUOTE;
            end else begin
               b = stfp_pkg::push_result(b, stfp_pkg::KIND_ERR, 16'h0, 16'h0);
               phase_in = PH_FAILED;
            end
         end
         PH_EQ_COMMENT: begin
            if (c == stfp_pkg::UNIT_LF) phase_in = PH_WANT_EQ;
         end
         PH_WANT_QUOTE: begin
            if (is_delim) begin
               phase_in = phase_ff;
            end else if (c == stfp_pkg::UNIT_SEMI) begin
               phase_in = PH_QUOTE_COMMENT;
            end else if (c == stfp_pkg::UNIT_QUOTE) begin
               phase_in = PH_TEXT;
            end else begin
               b = stfp_pkg::push_result(b, stfp_pkg::KIND_ERR, 16'h0, 16'h0);
               phase_in = PH_FAILED;
            end
         end
         PH_QUOTE_COMMENT: begin
            if (c == stfp_pkg::UNIT_LF) phase_in = PH_WANT_QUOTE;
         end
         PH_TEXT: begin
            if (c == stfp_pkg::UNIT_QUOTE) begin
               b = stfp_pkg::push_result(b, stfp_pkg::KIND_END, entry, 16'h0);
               phase_in = PH_BETWEEN;
            end else if (c == stfp_pkg::UNIT_BACKSLASH) begin
               phase_in = PH_ESCAPE;
            end else begin
               b = stfp_pkg::push_result(b, stfp_pkg::KIND_TEXT, entry, c);
               len_in = len1;
               if (len1 >= stfp_pkg::LEN_W'(stfp_pkg::MAX_TEXT)) begin
                  b = stfp_pkg::push_result(b, stfp_pkg::KIND_ERR, 16'h0, 16'h0);
                  phase_in = PH_FAILED;
               end
            end
         end
         PH_ESCAPE: begin
            phase_in = PH_TEXT;
            if (esc_known) begin
               b = stfp_pkg::push_result(b, stfp_pkg::KIND_TEXT, entry, esc_unit);
               len_in = len1;
               if (len1 >= stfp_pkg::LEN_W'(stfp_pkg::MAX_TEXT)) begin
                  b = stfp_pkg::push_result(b, stfp_pkg::KIND_ERR, 16'h0, 16'h0);
                  phase_in = PH_FAILED;
               end
            end else begin
               b = stfp_pkg::push_result(b, stfp_pkg::KIND_TEXT, entry,
                                         stfp_pkg::UNIT_BACKSLASH);
               len_in = len1;
               if (len1 >= stfp_pkg::LEN_W'(stfp_pkg::MAX_TEXT)) begin
                  b = stfp_pkg::push_result(b, stfp_pkg::KIND_ERR, 16'h0, 16'h0);
                  phase_in = PH_FAILED;
               end else begin
                  b = stfp_pkg::push_result(b, stfp_pkg::KIND_TEXT, entry, c);
                  len_in = len2;
                  if (len2 >= stfp_pkg::LEN_W'(stfp_pkg::MAX_TEXT)) begin
                     b = stfp_pkg::push_result(b, stfp_pkg::KIND_ERR, 16'h0, 16'h0);
                     phase_in = PH_FAILED;
                  end
               end
            end
         end
         PH_FAILED: phase_in = PH_FAILED;
         default: phase_in = PH_FAILED;
      endcase

      acc_wide = {acc_base, 3'b000} + {3'b000, acc_base, 1'b0} +
                 (stfp_pkg::ACC_W+4)'(c[3:0]);
      in_range = (acc_base >= {1'b0, cfg.id_lowest}) &&
                 (acc_base <= {1'b0, cfg.id_highest});
      if (run_id) begin
         acc_in = acc_base;
         if (c == stfp_pkg::UNIT_EQ || is_delim) begin
            if (in_range) begin
               phase_in = (c == stfp_pkg::UNIT_EQ) ? PH_WANT_QUOTE : PH_WANT_EQ;
            end else begin
               phase_in = (c == stfp_pkg::UNIT_LF) ? PH_BETWEEN : PH_SKIP_LINE;
            end
         end else if (is_digit) begin
            phase_in = PH_ID;
            if (acc_wide > (stfp_pkg::ACC_W+4)'(stfp_pkg::ACC_SAT)) begin
               acc_in = stfp_pkg::ACC_SAT;
            end else begin
               acc_in = acc_wide[stfp_pkg::ACC_W-1:0];
            end
         end else begin
            phase_in = PH_SKIP_LINE;
         end
      end

      if (req_final_unit) begin
         if (phase_in != PH_FAILED) begin
            if (phase_in == PH_BETWEEN || phase_in == PH_TOP_COMMENT) begin
               b = stfp_pkg::push_result(b, stfp_pkg::KIND_OK, 16'h0, 16'h0);
            end else begin
               b = stfp_pkg::push_result(b, stfp_pkg::KIND_ERR, 16'h0, 16'h0);
            end
         end
         phase_in = PH_BETWEEN;
         acc_in = '0;
         len_in = '0;
      end
   end

   assign push_valid = accept && (b.count != 2'd0);
   assign push_data = b;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         acc_ff <= '0;
         len_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         len_ff <= len_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/stfp_queue.sv
`default_nettype none

module stfp_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   input  wire stfp_pkg::bundle_type push_data,
   output logic full,
   input  wire logic pop,
   output logic nonempty,
   output stfp_pkg::bundle_type pop_data
);

   stfp_pkg::bundle_type mem_ff [stfp_pkg::QUEUE_DEPTH];
   logic [stfp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [stfp_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == stfp_pkg::QCNT_W'(stfp_pkg::QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop && nonempty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == stfp_pkg::QPTR_W'(stfp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + stfp_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == stfp_pkg::QPTR_W'(stfp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + stfp_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + stfp_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - stfp_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/stfp_back.sv
`default_nettype none

module stfp_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic queue_nonempty,
   input  wire stfp_pkg::bundle_type queue_data,
   output logic queue_pop,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output stfp_pkg::result_type rsp_data
);

   stfp_pkg::bundle_type slot_ff, slot_in;
   logic slot_valid_ff, slot_valid_in;
   logic [1:0] sub_ff, sub_in;
   logic taken, last_of_slot;

   assign rsp_valid = slot_valid_ff;
   assign rsp_data = slot_ff.item[sub_ff];
   assign taken = slot_valid_ff && rsp_ready;
   assign last_of_slot = (sub_ff + 2'd1 == slot_ff.count);

   always_comb begin
      slot_in = slot_ff;
      slot_valid_in = slot_valid_ff;
      sub_in = sub_ff;
      queue_pop = 1'b0;
      if (taken && !last_of_slot) begin
         sub_in = sub_ff + 2'd1;
      end else if (!slot_valid_ff || taken) begin
         // refill the slot
         slot_valid_in = queue_nonempty;
         queue_pop = queue_nonempty;
         slot_in = queue_data;
         sub_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         sub_ff <= 2'd0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         sub_ff <= sub_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/string_table_file_parser_top.sv
// String table file parser: takes the 16-bit text units of a file (after its byte-order
// mark) on req_chan, one unit per request, and delivers text units, end-of-entry marks
// and a final ok/error status on rsp_chan. The front end parses one unit per cycle and
// hands the up to three results it causes to a four-deep queue; the back end delivers
// one result per cycle from that queue while rsp_chan.ready is high. Requests are
// accepted every cycle while the queue has room. The entry id window is set through
// csr_index 0 (lowest) and 1 (highest); the user must write it only while idle, which
// the block itself does not enforce. There is no clearing pass after reset.
`default_nettype none

module string_table_file_parser_top (
   input  wire logic clock,
   input  wire logic reset,
   stfp_req_if.sink req_chan,
   stfp_rsp_if.source rsp_chan,
   input  wire logic csr_write_enable,
   input  wire logic [stfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0] csr_write_data
);

   stfp_pkg::cfg_type cfg_ff;
   stfp_pkg::bundle_type push_data, pop_data;
   stfp_pkg::result_type rsp_data;
   logic push_valid, queue_full, queue_pop, queue_nonempty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.id_lowest <= stfp_pkg::ID_LOWEST_RESET;
         cfg_ff.id_highest <= stfp_pkg::ID_HIGHEST_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == stfp_pkg::CSR_ID_LOWEST) begin
            cfg_ff.id_lowest <= csr_write_data;
         end
         if (csr_index == stfp_pkg::CSR_ID_HIGHEST) begin
            cfg_ff.id_highest <= csr_write_data;
         end
      end
   end

   stfp_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .req_code_unit(req_chan.code_unit),
      .req_final_unit(req_chan.final_unit),
      .queue_full(queue_full),
      .push_valid(push_valid),
      .push_data(push_data)
   );

   stfp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_data(push_data),
      .full(queue_full),
      .pop(queue_pop),
      .nonempty(queue_nonempty),
      .pop_data(pop_data)
   );

   stfp_back u_back (
      .clock(clock),
      .reset(reset),
      .queue_nonempty(queue_nonempty),
      .queue_data(pop_data),
      .queue_pop(queue_pop),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .rsp_data(rsp_data)
   );

   assign rsp_chan.kind = rsp_data.kind;
   assign rsp_chan.entry_id = rsp_data.entry_id;
   assign rsp_chan.text_unit = rsp_data.text_unit;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS = 140;
   localparam int NUM_WINDOWS = 7;

   typedef enum int {
      PH_BETWEEN,
      PH_TOP_COMMENT,
      PH_ID,
      PH_SKIP_LINE,
      PH_WANT_EQ,
      PH_EQ_COMMENT,
      PH_WANT_QUOTE,
      PH_QUOTE_COMMENT,
      PH_TEXT,
      PH_ESCAPE,
      PH_FAILED
   } parse_phase_type;

   class parse_scoreboard;
      stfp_pkg::result_type pending_q[$];
      logic [15:0] id_low;
      logic [15:0] id_high;
      parse_phase_type phase;
      logic [16:0] acc;
      int unsigned text_len;
      int produced;
      int mismatches;
      int kind_seen[4];

      function new();
         id_low = stfp_pkg::ID_LOWEST_RESET;
         id_high = stfp_pkg::ID_HIGHEST_RESET;
         mismatches = 0;
         produced = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
         start_file();
      endfunction

      function void start_file();
         phase = PH_BETWEEN;
         acc = '0;
         text_len = 0;
      endfunction

      function void set_reg(stfp_pkg::csr_index_type idx, logic [15:0] value);
         if (idx == stfp_pkg::CSR_ID_LOWEST) id_low = value;
         else id_high = value;
      endfunction

      function bit is_delim(logic [15:0] c);
         return c == stfp_pkg::UNIT_SPACE || c == stfp_pkg::UNIT_LF ||
                c == stfp_pkg::UNIT_CR || c == stfp_pkg::UNIT_NUL ||
                c == stfp_pkg::UNIT_TAB;
      endfunction

      function void push(stfp_pkg::kind_type k, logic [15:0] id, logic [15:0] u);
         stfp_pkg::result_type r;
         if (produced < 3) begin
            r.kind = k;
            r.entry_id = id;
            r.text_unit = u;
            pending_q.push_back(r);
            produced++;
         end
      endfunction

      function void fail_file();
         push(stfp_pkg::KIND_ERR, 16'h0000, 16'h0000);
         phase = PH_FAILED;
      endfunction

      function bit put_text(logic [15:0] u);
         push(stfp_pkg::KIND_TEXT, acc[15:0], u);
         text_len++;
         if (text_len >= stfp_pkg::MAX_TEXT) begin
            fail_file();
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void id_done(logic [15:0] c);
         if (acc >= {1'b0, id_low} && acc <= {1'b0, id_high}) begin
            phase = (c == stfp_pkg::UNIT_EQ) ? PH_WANT_QUOTE : PH_WANT_EQ;
         end else begin
            phase = (c == stfp_pkg::UNIT_LF) ? PH_BETWEEN : PH_SKIP_LINE;
         end
      endfunction

      function void id_unit(logic [15:0] c);
         int unsigned v;
         if (c == stfp_pkg::UNIT_EQ || is_delim(c)) begin
            id_done(c);
         end else if (c >= stfp_pkg::UNIT_ZERO && c <= stfp_pkg::UNIT_NINE) begin
            v = 32'(acc) * 32'd10 + 32'(c - stfp_pkg::UNIT_ZERO);
            acc = (v > 32'(stfp_pkg::ACC_SAT)) ? stfp_pkg::ACC_SAT : v[16:0];
         end else begin
            phase = PH_SKIP_LINE;
         end
      endfunction

      function void note_request(logic [15:0] c, bit last);
         produced = 0;
         case (phase)
            PH_BETWEEN: begin
               if (!is_delim(c)) begin
                  if (c == stfp_pkg::UNIT_SEMI) begin
                     phase = PH_TOP_COMMENT;
                  end else begin
                     acc = '0;
                     text_len = 0;
                     phase = PH_ID;
                     id_unit(c);
                  end
               end
            end
            PH_TOP_COMMENT, PH_SKIP_LINE: begin
               if (c == stfp_pkg::UNIT_LF) phase = PH_BETWEEN;
            end
            PH_ID: id_unit(c);
            PH_WANT_EQ: begin
               if (!is_delim(c)) begin
                  if (c == stfp_pkg::UNIT_SEMI) phase = PH_EQ_COMMENT;
                  else if (c == stfp_pkg::UNIT_EQ) phase = PH_WANT_QUOTE;
                  else fail_file();
               end
            end
            PH_EQ_COMMENT: begin
               if (c == stfp_pkg::UNIT_LF) phase = PH_WANT_EQ;
            end
            PH_WANT_QUOTE: begin
               if (!is_delim(c)) begin
                  if (c == stfp_pkg::UNIT_SEMI) phase = PH_QUOTE_COMMENT;
                  else if (c == stfp_pkg::UNIT_QUOTE) phase = PH_TEXT;
                  else fail_file();
               end
            end
            PH_QUOTE_COMMENT: begin
               if (c == stfp_pkg::UNIT_LF) phase = PH_WANT_QUOTE;
            end
            PH_TEXT: begin
               if (c == stfp_pkg::UNIT_QUOTE) begin
                  push(stfp_pkg::KIND_END, acc[15:0], 16'h0000);
                  phase = PH_BETWEEN;
               end else if (c == stfp_pkg::UNIT_BACKSLASH) begin
                  phase = PH_ESCAPE;
               end else begin
                  void'(put_text(c));
               end
            end
            PH_ESCAPE: begin
               phase = PH_TEXT;
               if (c == stfp_pkg::UNIT_R) void'(put_text(stfp_pkg::UNIT_CR));
               else if (c == stfp_pkg::UNIT_N) void'(put_text(stfp_pkg::UNIT_LF));
               else if (c == stfp_pkg::UNIT_T) void'(put_text(stfp_pkg::UNIT_TAB));
               else if (c == stfp_pkg::UNIT_BACKSLASH || c == stfp_pkg::UNIT_QUOTE)
                  void'(put_text(c));
               else if (put_text(stfp_pkg::UNIT_BACKSLASH)) void'(put_text(c));
            end
            default: phase = PH_FAILED;
         endcase
         if (last) begin
            if (phase != PH_FAILED) begin
               if (phase == PH_BETWEEN || phase == PH_TOP_COMMENT)
                  push(stfp_pkg::KIND_OK, 16'h0000, 16'h0000);
               else
                  push(stfp_pkg::KIND_ERR, 16'h0000, 16'h0000);
            end
            start_file();
         end
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(logic [1:0] kind, logic [15:0] id, logic [15:0] unit);
         stfp_pkg::result_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result kind %0d id %0d unit 0x%04h", kind, id, unit));
            return;
         end
         want = pending_q.pop_front();
         kind_seen[kind]++;
         if (kind !== want.kind || id !== want.entry_id || unit !== want.text_unit)
            report($sformatf("got kind %0d id %0d unit 0x%04h, want kind %0d id %0d unit 0x%04h",
                             kind, id, unit, want.kind, want.entry_id, want.text_unit));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   stfp_pkg::csr_index_type csr_index;
   logic [15:0] csr_write_data;

   stfp_req_if req_if();
   stfp_rsp_if rsp_if();

   string_table_file_parser_top dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   parse_scoreboard sb = new();

   logic [15:0] file_q[$];
   bit no_idle = 1'b0;
   int hold_asked = 0;
   int items_sent = 0;
   int files_sent = 0;
   int idle_cycles = 0;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response side back-pressure
   initial begin
      int stall;
      int hold_done;
      stall = 0;
      hold_done = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            stall = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.code_unit, req_if.final_unit);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.kind, rsp_if.entry_id, rsp_if.text_unit);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("** string_table_file_parser_top: FAILED **");
         $finish;
      end
   end

   task automatic send_unit(logic [15:0] unit, bit last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.code_unit <= unit;
      req_if.final_unit <= last;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_q.size(); i++) send_unit(file_q[i], i == file_q.size() - 1);
      files_sent++;
      file_q.delete();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(stfp_pkg::csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   function automatic void add_char(byte ch);
      file_q.push_back({8'h00, ch});
   endfunction

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endfunction

   function automatic logic [15:0] printable();
      logic [15:0] r;
      do r = 16'($urandom_range(16'h20, 16'h7E));
      while (r == stfp_pkg::UNIT_QUOTE || r == stfp_pkg::UNIT_BACKSLASH);
      return r;
   endfunction

   function automatic void add_delims(int max_count);
      int n;
      n = $urandom_range(0, max_count);
      repeat (n) begin
         case ($urandom_range(0, 4))
            0: file_q.push_back(stfp_pkg::UNIT_SPACE);
            1: file_q.push_back(stfp_pkg::UNIT_TAB);
            2: file_q.push_back(stfp_pkg::UNIT_CR);
            3: file_q.push_back(stfp_pkg::UNIT_NUL);
            default: file_q.push_back(stfp_pkg::UNIT_LF);
         endcase
      end
   endfunction

   function automatic void add_comment();
      file_q.push_back(stfp_pkg::UNIT_SEMI);
      repeat ($urandom_range(0, 4)) file_q.push_back(printable());
      file_q.push_back(stfp_pkg::UNIT_LF);
   endfunction

   function automatic void add_rest_of_line();
      repeat ($urandom_range(0, 5)) file_q.push_back(printable());
      file_q.push_back(stfp_pkg::UNIT_LF);
   endfunction

   function automatic void add_id(int unsigned v);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) add_char("0");
      add_str($sformatf("%0d", v));
   endfunction

   function automatic int unsigned pick_id(int unsigned lo, int unsigned hi);
      case ($urandom_range(0, 3))
         0: return lo;
         1: return hi;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   function automatic void add_text(int len);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: file_q.push_back(printable());
            6: file_q.push_back(16'($urandom_range(0, 65535)));
            default: begin
               file_q.push_back(stfp_pkg::UNIT_BACKSLASH);
               case ($urandom_range(0, 6))
                  0: file_q.push_back(stfp_pkg::UNIT_R);
                  1: file_q.push_back(stfp_pkg::UNIT_N);
                  2: file_q.push_back(stfp_pkg::UNIT_T);
                  3: file_q.push_back(stfp_pkg::UNIT_BACKSLASH);
                  4: file_q.push_back(stfp_pkg::UNIT_QUOTE);
                  5: file_q.push_back(printable());
                  default: file_q.push_back(16'($urandom_range(0, 65535)));
               endcase
            end
         endcase
      end
   endfunction

   function automatic void add_good_entry(int unsigned lo, int unsigned hi);
      if (!(lo == 0 && $urandom_range(0, 7) == 0)) begin
         add_id(pick_id(lo, hi));
         if ($urandom_range(0, 1) == 1) begin
            file_q.push_back($urandom_range(0, 1) ? stfp_pkg::UNIT_SPACE : stfp_pkg::UNIT_TAB);
            add_delims(2);
            if ($urandom_range(0, 4) == 0) add_comment();
         end
      end
      file_q.push_back(stfp_pkg::UNIT_EQ);
      add_delims(2);
      if ($urandom_range(0, 4) == 0) add_comment();
      file_q.push_back(stfp_pkg::UNIT_QUOTE);
      if ($urandom_range(0, 9) == 0) add_text($urandom_range(7, 30));
      else add_text($urandom_range(0, 6));
      file_q.push_back(stfp_pkg::UNIT_QUOTE);
      if ($urandom_range(0, 9) < 7) file_q.push_back(stfp_pkg::UNIT_LF);
      else add_delims(1);
   endfunction

   function automatic void add_line(int unsigned lo, int unsigned hi);
      int r;
      int unsigned v;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         add_good_entry(lo, hi);
      end else if (r < 58) begin
         add_comment();
      end else if (r < 63) begin
         add_delims(3);
      end else if (r < 71) begin
         // non-digit inside the id
         add_id($urandom_range(0, 65535));
         add_char(byte'($urandom_range(8'h61, 8'h7A)));
         add_rest_of_line();
      end else if (r < 81) begin
         if (lo > 0) v = $urandom_range(lo - 1, 0);
         else if (hi < 65535) v = $urandom_range(hi + 1, 65535);
         else v = $urandom_range(65536, 131071);
         add_id(v);
         case ($urandom_range(0, 2))
            0: file_q.push_back(stfp_pkg::UNIT_LF);
            1: begin
               file_q.push_back(stfp_pkg::UNIT_EQ);
               add_rest_of_line();
            end
            default: begin
               file_q.push_back(stfp_pkg::UNIT_SPACE);
               add_rest_of_line();
            end
         endcase
      end else if (r < 87) begin
         // accumulator saturation
         add_str("9999999");
         repeat ($urandom_range(0, 3)) add_char(byte'($urandom_range(8'h30, 8'h39)));
         add_str("=\"ab\"");
         file_q.push_back(stfp_pkg::UNIT_LF);
      end else if (r < 94) begin
         add_id(pick_id(lo, hi));
         file_q.push_back(stfp_pkg::UNIT_SPACE);
         add_delims(1);
         add_char(byte'($urandom_range(8'h61, 8'h7A)));
         add_rest_of_line();
      end else begin
         add_id(pick_id(lo, hi));
         file_q.push_back(stfp_pkg::UNIT_EQ);
         add_delims(1);
         add_char(byte'($urandom_range(8'h61, 8'h7A)));
         add_rest_of_line();
      end
   endfunction

   task automatic run_random_file(int unsigned lo, int unsigned hi);
      int r;
      int unsigned cut;
      repeat ($urandom_range(1, 4)) add_line(lo, hi);
      r = $urandom_range(0, 99);
      if (r >= 70 && r < 85 && file_q.size() > 1) begin
         cut = $urandom_range(0, file_q.size() - 2);
         file_q = file_q[0:cut];
      end else if (r >= 85) begin
         file_q.push_back(16'($urandom_range(0, 65535)));
      end
      if (file_q.size() == 0) file_q.push_back(stfp_pkg::UNIT_LF);
      send_file();
   endtask

   // text limit reached on the backslash of an unknown escape
   task automatic run_long_text_file(int unsigned lo);
      add_id(lo);
      file_q.push_back(stfp_pkg::UNIT_EQ);
      file_q.push_back(stfp_pkg::UNIT_QUOTE);
      repeat (stfp_pkg::MAX_TEXT - 1) file_q.push_back(printable());
      add_str("\\x\"");
      file_q.push_back(stfp_pkg::UNIT_LF);
      send_file();
   endtask

   initial begin
      int unsigned lo_list[NUM_WINDOWS];
      int unsigned hi_list[NUM_WINDOWS];
      int start_items;
      req_if.valid = 1'b0;
      req_if.code_unit = 16'h0000;
      req_if.final_unit = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = stfp_pkg::CSR_ID_LOWEST;
      csr_write_data = 16'h0000;
      reset = 1'b1;
      lo_list = '{0, 0, 65535, 100, 5000, 31000, 0};
      hi_list = '{65535, 0, 65535, 5000, 100, 65535, 0};
      lo_list[NUM_WINDOWS - 1] = $urandom_range(0, 40000);
      hi_list[NUM_WINDOWS - 1] = $urandom_range(lo_list[NUM_WINDOWS - 1], 65535);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty file
      file_q.push_back(stfp_pkg::UNIT_LF);
      send_file();
      // top id, extreme text units, unknown and known escapes
      add_str("65535=\"");
      file_q.push_back(16'hFFFF);
      add_str("\\q\\n\"");
      file_q.push_back(stfp_pkg::UNIT_NUL);
      send_file();
      // out-of-range id, file ends in the skipped line
      add_str("9 x");
      send_file();
      // missing '=' after a comment, trailing unit ignored
      add_str("31000 ;c");
      file_q.push_back(stfp_pkg::UNIT_LF);
      add_str(" xy");
      send_file();
      wait_drained();

      for (int w = 0; w < NUM_WINDOWS; w++) begin
         write_reg(stfp_pkg::CSR_ID_LOWEST, 16'(lo_list[w]));
         write_reg(stfp_pkg::CSR_ID_HIGHEST, 16'(hi_list[w]));
         no_idle = (w == 5);
         start_items = items_sent;
         if (w == 0) begin
            // long text streamed while the receiver holds off
            hold_asked++;
            no_idle = 1'b1;
            run_long_text_file(lo_list[w]);
            no_idle = 1'b0;
            wait_drained();
            start_items = items_sent;
         end
         while (items_sent - start_items < RANDOM_ITEMS / NUM_WINDOWS)
            run_random_file(lo_list[w], hi_list[w]);
         wait_drained();
      end
      no_idle = 1'b0;

      $display("covered %0d requests in %0d files over %0d id windows",
               items_sent, files_sent, NUM_WINDOWS + 1);
      $display("results checked: %0d text, %0d end of entry, %0d ok, %0d error",
               sb.kind_seen[stfp_pkg::KIND_TEXT], sb.kind_seen[stfp_pkg::KIND_END],
               sb.kind_seen[stfp_pkg::KIND_OK], sb.kind_seen[stfp_pkg::KIND_ERR]);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("** string_table_file_parser_top: PASSED **");
      end else begin
         $display("** string_table_file_parser_top: FAILED **");
      end
      $finish;
   end

endmodule
